// ===== hw/rtl/bda_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the binary to decimal ascii unit
// no dependencies

package bda_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int FIELD_WIDTH     = 64;
  localparam int CHAR_WIDTH      = 8;
  localparam int DIGIT_WIDTH     = 4;

  localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0]  CHAR_MINUS = 8'h2D;
  localparam logic [DIGIT_WIDTH-1:0] DIGIT_FIVE = 4'd5;
  localparam logic [DIGIT_WIDTH-1:0] DIGIT_ADJ  = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } bda_state_t;

  typedef struct packed {
    logic clear;
    logic dabble;
    logic digit_shift;
    logic bit_in;
  } bda_shift_ctrl_t;

endpackage

// ===== hw/rtl/binary_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps
// binary to decimal ascii unit: one word in, its decimal text out one character per transfer
// depends on bda_pkg and bda_bcd_shifter
//
// usage
//   a word is taken when start is high and busy is low. in_signed_mode selects
//   two's complement; a negative word gives '-' and then the digits of its magnitude.
//   characters come most significant first with no leading zeros, one per
//   out_valid pulse, and out_last marks the final one. a zero word gives '0'.
//   the receiver cannot hold results off; each is shown for exactly one cycle.
// operation
//   bit-serial double dabble over the word, then the bcd register is shifted
//   out one digit a cycle. busy stays high through both phases, so a new word
//   is taken only once the last one has been converted and shifted out.
//   '-' appears while the digits are still forming; the last digit appears
//   once the bcd register has been shifted out.
// reset
//   synchronous active-low reset returns the unit to idle and drops out_valid.

module binary_to_decimal_ascii_unit import bda_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [FIELD_WIDTH-1:0] in_value,
  input  logic                  in_signed_mode,
  output logic                  out_valid,
  output logic [CHAR_WIDTH-1:0] out_character,
  output logic                  out_last
);

  // digits of 2^VALUE_WIDTH, using 1233/4096 for log10(2)
  localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  bda_state_t state_r, state_nxt;

  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]   dig_cnt_r, dig_cnt_nxt;
  logic                   started_r, started_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_WIDTH-1:0]  out_character_r, out_character_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [VALUE_WIDTH-1:0] in_word;
  logic                   in_neg;
  logic                   show;
  logic [DIGIT_WIDTH-1:0] top_digit;
  bda_shift_ctrl_t        shift_ctrl;

  bda_bcd_shifter #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_bcd (
    .clk      (clk),
    .ctrl     (shift_ctrl),
    .top_digit(top_digit)
  );

  assign in_word = in_value[VALUE_WIDTH-1:0];
  assign in_neg  = in_signed_mode && in_word[VALUE_WIDTH-1];
  assign show    = started_r || (top_digit != '0) || (dig_cnt_r == DIG_CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    mag_r           <= mag_nxt;
    neg_r           <= neg_nxt;
    bit_cnt_r       <= bit_cnt_nxt;
    dig_cnt_r       <= dig_cnt_nxt;
    started_r       <= started_nxt;
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
  end

  always_comb begin
    state_nxt         = state_r;
    mag_nxt           = mag_r;
    neg_nxt           = neg_r;
    bit_cnt_nxt       = bit_cnt_r;
    dig_cnt_nxt       = dig_cnt_r;
    started_nxt       = started_r;
    out_valid_nxt     = 1'b0;
    out_character_nxt = CHAR_ZERO + {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, top_digit};
    out_last_nxt      = 1'b0;
    shift_ctrl        = '0;
    shift_ctrl.bit_in = mag_r[VALUE_WIDTH-1];
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          mag_nxt          = in_neg ? (~in_word + VALUE_WIDTH'(1)) : in_word;
          neg_nxt          = in_neg;
          bit_cnt_nxt      = BIT_CNT_W'(VALUE_WIDTH - 1);
          shift_ctrl.clear = 1'b1;
          state_nxt        = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        shift_ctrl.dabble = 1'b1;
        mag_nxt           = {mag_r[VALUE_WIDTH-2:0], 1'b0};
        // sign goes out while the digits are still forming
        if (neg_r && (bit_cnt_r == BIT_CNT_W'(VALUE_WIDTH - 1))) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = CHAR_MINUS;
        end
        if (bit_cnt_r == '0) begin
          dig_cnt_nxt = DIG_CNT_W'(NUM_DIGITS);
          started_nxt = 1'b0;
          state_nxt   = ST_EMIT;
        end else begin
          bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
        end
      end
      ST_EMIT: begin
        shift_ctrl.digit_shift = 1'b1;
        out_valid_nxt          = show;
        out_last_nxt           = (dig_cnt_r == DIG_CNT_W'(1));
        started_nxt            = started_r || show;
        if (dig_cnt_r == DIG_CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end else begin
          dig_cnt_nxt = dig_cnt_r - DIG_CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a word in progress");

  a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not start conversion");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result right after final character");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_character == CHAR_MINUS) |-> !out_last)
    else $error("sign marked as final character");

endmodule

// ===== hw/rtl/bda_bcd_shifter.sv =====
`timescale 1ns / 1ps
// bcd shift register: bit-serial double dabble in, digit-serial out
// depends on bda_pkg

module bda_bcd_shifter import bda_pkg::*; #(
  parameter int NUM_DIGITS = 20
) (
  input  logic                   clk,
  input  bda_shift_ctrl_t        ctrl,
  output logic [DIGIT_WIDTH-1:0] top_digit
);

  localparam int BCD_WIDTH = NUM_DIGITS * DIGIT_WIDTH;

  logic [BCD_WIDTH-1:0] bcd_r;
  logic [BCD_WIDTH-1:0] bcd_nxt;
  logic [BCD_WIDTH-1:0] adjusted;

  // add 3 to every digit of five or more before the doubling shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*DIGIT_WIDTH +: DIGIT_WIDTH] >= DIGIT_FIVE) begin
        adjusted[i*DIGIT_WIDTH +: DIGIT_WIDTH] =
          bcd_r[i*DIGIT_WIDTH +: DIGIT_WIDTH] + DIGIT_ADJ;
      end else begin
        adjusted[i*DIGIT_WIDTH +: DIGIT_WIDTH] = bcd_r[i*DIGIT_WIDTH +: DIGIT_WIDTH];
      end
    end
  end

  always_comb begin
    bcd_nxt = bcd_r;
    if (ctrl.clear) begin
      bcd_nxt = '0;
    end else if (ctrl.dabble) begin
      bcd_nxt = {adjusted[BCD_WIDTH-2:0], ctrl.bit_in};
    end else if (ctrl.digit_shift) begin
      bcd_nxt = {bcd_r[BCD_WIDTH-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_WIDTH-1 -: DIGIT_WIDTH];

endmodule

// ===== dv/bda_checker.sv =====
`timescale 1ns / 1ps
// checker for the binary to decimal ascii unit: watches word and character transfers,
// predicts the decimal text of each word and compares every character in order
// depends on bda_pkg

module bda_checker import bda_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic [FIELD_WIDTH-1:0] in_value,
  input  logic                   in_signed_mode,
  input  logic                   out_valid,
  input  logic [CHAR_WIDTH-1:0]  out_character,
  input  logic                   out_last,
  output int                     mismatches,
  output int                     chars_pending
);

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] ch;
    logic                  last;
  } text_char_t;

  text_char_t expected_text[$];

  task automatic report_mismatch(input string what, input logic [CHAR_WIDTH-1:0] want,
                                 input logic [CHAR_WIDTH-1:0] got);
    $display("%0t ERROR %s: expected %h got %h", $time, what, want, got);
    mismatches++;
  endtask

  function automatic void predict_text(input logic [FIELD_WIDTH-1:0] raw, input logic sgn);
    logic [63:0]            mask;
    logic [63:0]            mag;
    logic [DIGIT_WIDTH-1:0] digits[20];
    int                     nd;
    text_char_t             c;
    mask = {64{1'b1}} >> (64 - VALUE_WIDTH);
    mag  = raw & mask;
    nd   = 0;
    if (sgn && mag[VALUE_WIDTH-1]) begin
      c.ch   = CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
      // magnitude of the most negative word wraps back to itself, which is correct unsigned
      mag = (~mag + 64'd1) & mask;
    end
    // least significant digit first, at least one digit
    do begin
      digits[nd] = DIGIT_WIDTH'(mag % 64'd10);
      mag        = mag / 64'd10;
      nd++;
    end while (mag != 64'd0 && nd < 20);
    for (int k = nd - 1; k >= 0; k--) begin
      c.ch   = CHAR_ZERO + {4'b0000, digits[k]};
      c.last = (k == 0);
      expected_text.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (start && !busy) begin
        predict_text(in_value, in_signed_mode);
      end
      if (out_valid) begin
        if (expected_text.size() == 0) begin
          report_mismatch("character transfer with no text pending", 8'h00, out_character);
        end else begin
          want = expected_text.pop_front();
          if (out_character !== want.ch) begin
            report_mismatch("character", want.ch, out_character);
          end
          if (out_last !== want.last) begin
            report_mismatch("last flag", {7'b0, want.last}, {7'b0, out_last});
          end
        end
      end
    end
    chars_pending = expected_text.size();
  end

endmodule

// ===== dv/tb_binary_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps
// top of the binary to decimal ascii unit testbench: clock, reset, word stimulus and verdict
// depends on bda_pkg, binary_to_decimal_ascii_unit and bda_checker

module tb_binary_to_decimal_ascii_unit import bda_pkg::*;;

  localparam int RANDOM_WORDS = 300;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [FIELD_WIDTH-1:0] in_value;
  logic                   in_signed_mode;
  logic                   out_valid;
  logic [CHAR_WIDTH-1:0]  out_character;
  logic                   out_last;
  int                     mismatches;
  int                     chars_pending;

  logic [63:0]            pow10[20];

  binary_to_decimal_ascii_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .in_signed_mode (in_signed_mode),
    .out_valid      (out_valid),
    .out_character  (out_character),
    .out_last       (out_last)
  );

  bda_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .in_signed_mode (in_signed_mode),
    .out_valid      (out_valid),
    .out_character  (out_character),
    .out_last       (out_last),
    .mismatches     (mismatches),
    .chars_pending  (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_word(input logic [63:0] v, input logic sgn, input int idle_pct);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 90);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start          <= 1'b1;
    in_value       <= v;
    in_signed_mode <= sgn;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [63:0] random_word();
    int          kind;
    int          len;
    logic [63:0] r;
    r    = {$urandom, $urandom};
    kind = $urandom_range(3);
    case (kind)
      0: return r;
      1: begin
        len = $urandom_range(1, 64);
        return r >> (64 - len);
      end
      2: return pow10[$urandom_range(19)] + 64'($urandom_range(4)) - 64'd2;
      default: begin
        len = $urandom_range(1, 63);
        return ~(r >> (64 - len)) + 64'd1;
      end
    endcase
  endfunction

  initial begin
    int idle_pct;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_value       = '0;
    in_signed_mode = 1'b0;
    pow10[0] = 64'd1;
    for (int k = 1; k < 20; k++) pow10[k] = pow10[k-1] * 64'd10;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes, zero, sign boundaries and digit count boundaries
    send_word(64'd0, 1'b0, 19);
    send_word(64'd0, 1'b1, 19);
    send_word(64'd1, 1'b0, 19);
    send_word(64'd9, 1'b1, 19);
    send_word(64'd10, 1'b0, 19);
    send_word(64'd99, 1'b0, 19);
    send_word(64'd100, 1'b1, 19);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 19);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 19);
    send_word(64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 19);
    send_word(64'hFFFF_FFFF_FFFF_FFF6, 1'b1, 19);
    send_word(64'h8000_0000_0000_0000, 1'b1, 19);
    send_word(64'h8000_0000_0000_0000, 1'b0, 19);
    send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 19);
    send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 19);
    send_word(pow10[19] - 64'd1, 1'b0, 19);
    send_word(pow10[19], 1'b0, 19);
    send_word(pow10[19], 1'b1, 19);
    send_word(64'd123456789, 1'b1, 19);
    send_word(64'hAAAA_AAAA_5555_5555, 1'b0, 19);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      idle_pct = (i < RANDOM_WORDS / 3) ? 19 : (i < 2 * RANDOM_WORDS / 3) ? 85 : 0;
      send_word(random_word(), 1'($urandom_range(1)), idle_pct);
    end
    start <= 1'b0;

    wait (chars_pending == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bda_pkg.sv
hw/rtl/bda_bcd_shifter.sv
hw/rtl/binary_to_decimal_ascii_unit.sv
dv/bda_checker.sv
dv/tb_binary_to_decimal_ascii_unit.sv
